// ===== sv/psu_pkg.sv =====
// ----------------------------------------------------------------------------
// psu_pkg
// Shared types, widths and helpers for the particle store update core.
// ----------------------------------------------------------------------------
package psu_pkg;

    localparam int SlotsDefault = 64;
    localparam int PackW  = 63;
    localparam int LaneW  = 21;
    localparam int TimeW  = 32;
    localparam int LifeW  = 24;
    localparam int DtW    = 16;
    localparam int RadW   = 16;
    localparam int ColW   = 32;
    localparam int AgeW   = 16;
    localparam int InDataW  = 328;   // 325 field bits padded to bytes
    localparam int OutDataW = 120;   // 117 field bits padded to bytes

    typedef enum logic {
        ACT_EMIT = 1'b0,
        ACT_TICK = 1'b1
    } action_t;

    // Classified command from the front part to the back part.
    typedef struct packed {
        action_t          act;
        logic [PackW-1:0] pos;
        logic [PackW-1:0] vel;
        logic [PackW-1:0] acc;
        logic [LifeW-1:0] life;
        logic [DtW-1:0]   dt;
        logic [RadW-1:0]  rad_s;
        logic [RadW-1:0]  rad_e;
        logic [ColW-1:0]  col_s;
        logic [ColW-1:0]  col_e;
    } cmd_t;

    function automatic logic signed [LaneW-1:0] sat21(input logic signed [47:0] v);
        logic signed [47:0] hi;
        logic signed [47:0] lo;
        hi = 48'sd1048575;
        lo = -48'sd1048576;
        if (v > hi) return LaneW'(hi);
        if (v < lo) return LaneW'(lo);
        return v[LaneW-1:0];
    endfunction

    function automatic logic [TimeW-1:0] sat_add(input logic [TimeW-1:0] a,
                                                 input logic [TimeW-1:0] b);
        logic [TimeW:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[TimeW] ? {TimeW{1'b1}} : s[TimeW-1:0];
    endfunction

endpackage

// ===== sv/psu_front.sv =====
// ----------------------------------------------------------------------------
// psu_front
// Accepts input transfers, classifies them and queues commands (2 deep).
// ----------------------------------------------------------------------------
module psu_front
    import psu_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [InDataW-1:0]  s_tdata,
    input  logic                s_tuser,
    output logic                cmd_valid,
    input  logic                cmd_ready,
    output cmd_t                cmd
);
    cmd_t       q_reg [2];
    logic       wp_reg, rp_reg;
    logic [1:0] cnt_reg;
    cmd_t       in_cmd;
    logic       push, pop;

    always_comb
    begin
        in_cmd.act   = action_t'(s_tuser);
        in_cmd.pos   = s_tdata[62:0];
        in_cmd.vel   = s_tdata[125:63];
        in_cmd.acc   = s_tdata[188:126];
        in_cmd.life  = s_tdata[212:189];
        in_cmd.dt    = s_tdata[228:213];
        in_cmd.rad_s = s_tdata[244:229];
        in_cmd.rad_e = s_tdata[260:245];
        in_cmd.col_s = s_tdata[292:261];
        in_cmd.col_e = s_tdata[324:293];
    end

    assign s_tready  = (cnt_reg != 2'd2);
    assign cmd_valid = (cnt_reg != 2'd0);
    assign cmd       = q_reg[rp_reg];
    assign push      = s_tvalid && s_tready;
    assign pop       = cmd_valid && cmd_ready;

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_reg[wp_reg] <= in_cmd;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end
        else
        begin
            if (push) wp_reg <= ~wp_reg;
            if (pop)  rp_reg <= ~rp_reg;
            cnt_reg <= cnt_reg + 2'(push) - 2'(pop);
        end
    end
endmodule

// ===== sv/psu_div.sv =====
// ----------------------------------------------------------------------------
// psu_div
// Restoring divider, one quotient bit per cycle: 48-bit / 32-bit -> 16 bits.
// Quotient is known to be below 2^16.
// ----------------------------------------------------------------------------
module psu_div
    import psu_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  logic [TimeW-1:0]    num,     // numerator before the << 16
    input  logic [TimeW-1:0]    den,
    output logic                done,
    output logic [AgeW-1:0]     quo
);
    logic [TimeW:0]   rem_reg;
    logic [AgeW-1:0]  q_reg;
    logic [TimeW-1:0] den_reg;
    logic [4:0]       cnt_reg;
    logic             busy_reg;
    logic [TimeW:0]   sh;
    logic [TimeW+1:0] diff;

    assign sh   = {rem_reg[TimeW-1:0], 1'b0};
    assign diff = {1'b0, sh} - {2'b00, den_reg};
    assign quo  = q_reg;
    assign done = busy_reg && (cnt_reg == 5'd0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= 5'd0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            cnt_reg  <= 5'd16;
        end
        else if (busy_reg)
        begin
            if (cnt_reg == 5'd0) busy_reg <= 1'b0;
            else cnt_reg <= cnt_reg - 5'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            // num < den, so the remainder starts as num itself
            rem_reg <= {1'b0, num};
            den_reg <= den;
            q_reg   <= '0;
        end
        else if (busy_reg && cnt_reg != 5'd0)
        begin
            if (!diff[TimeW+1])
            begin
                rem_reg <= diff[TimeW:0];
                q_reg   <= {q_reg[AgeW-2:0], 1'b1};
            end
            else
            begin
                rem_reg <= sh;
                q_reg   <= {q_reg[AgeW-2:0], 1'b0};
            end
        end
    end
endmodule

// ===== sv/psu_back.sv =====
// ----------------------------------------------------------------------------
// psu_back
// Executes emits and ticks on the slot memories; one result at a time.
// ----------------------------------------------------------------------------
module psu_back
    import psu_pkg::*;
#(
    parameter int SLOTS = SlotsDefault
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cmd_valid,
    output logic                cmd_ready,
    input  cmd_t                cmd,
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [OutDataW-1:0] m_tdata,
    output logic                m_tlast,
    output logic                m_tuser
);
    localparam int SW = (SLOTS > 1) ? $clog2(SLOTS) : 1;

    typedef enum logic [3:0] {
        S_IDLE, S_READ, S_CHECK, S_DIV, S_VEL, S_POS, S_LERP, S_OUT, S_NEXT, S_NONE
    } state_t;

    logic [PackW-1:0] pos_mem [SLOTS];
    logic [PackW-1:0] vel_mem [SLOTS];
    logic [PackW-1:0] acc_mem [SLOTS];
    logic [TimeW-1:0] bir_mem [SLOTS];
    logic [TimeW-1:0] dth_mem [SLOTS];
    logic [RadW-1:0]  rs_mem  [SLOTS];
    logic [RadW-1:0]  re_mem  [SLOTS];
    logic [ColW-1:0]  cs_mem  [SLOTS];
    logic [ColW-1:0]  ce_mem  [SLOTS];
    logic [SLOTS-1:0] vld_reg;     // slot written since reset

    state_t           st_reg;
    logic [SW-1:0]    wslot_reg, idx_reg;
    logic [TimeW-1:0] now_reg;
    logic [DtW-1:0]   dt_reg;
    logic [PackW-1:0] p_reg, v_reg, a_reg;
    logic [TimeW-1:0] b_reg, d_reg;
    logic [RadW-1:0]  rs_reg, re_reg, rad_reg;
    logic [ColW-1:0]  cs_reg, ce_reg, col_reg;
    logic [AgeW-1:0]  age_reg;
    logic             live_reg;
    logic             div_start, div_done;
    logic [AgeW-1:0]  div_q;
    logic [PackW-1:0] vnew, pnew;
    logic [ColW-1:0]  col_c;
    logic [RadW-1:0]  rad_c;
    logic             last_slot;

    // Output: one live result is held back so that the final one of a tick
    // can carry tlast; a single output register drives the bus.
    logic                hv_reg;
    logic [OutDataW-1:0] h_reg;
    logic                oval_reg, ol_reg, ousr_reg;
    logic [OutDataW-1:0] o_reg;
    logic                out_free;
    logic                load_out;
    logic [OutDataW-1:0] out_pkt;
    logic                out_last, out_live;
    logic [OutDataW-1:0] live_pkt;

    psu_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (now_reg - b_reg),
        .den   (d_reg - b_reg),
        .done  (div_done),
        .quo   (div_q)
    );

    assign div_start = (st_reg == S_CHECK) && live_reg;
    assign cmd_ready = (st_reg == S_IDLE);
    assign last_slot = (idx_reg == SW'(SLOTS - 1));

    function automatic logic signed [47:0] fl_mul(input logic signed [LaneW-1:0] x,
                                                  input logic [DtW-1:0] dt);
        return 48'(x) * $signed({1'b0, dt});
    endfunction

    function automatic logic [31:0] lerp(input logic [15:0] s, input logic [15:0] e,
                                         input logic [AgeW-1:0] age);
        logic signed [17:0] d;
        logic signed [35:0] pr;
        d  = $signed({2'b0, e}) - $signed({2'b0, s});
        pr = 36'(d) * $signed({1'b0, age});
        return 32'(s) + 32'(pr >>> 16);
    endfunction

    always_comb
    begin
        for (int l = 0; l < 3; l++)
        begin
            vnew[l*LaneW +: LaneW] = sat21(48'($signed(v_reg[l*LaneW +: LaneW]))
                + (fl_mul($signed(a_reg[l*LaneW +: LaneW]), dt_reg) >>> 8));
            pnew[l*LaneW +: LaneW] = sat21(48'($signed(p_reg[l*LaneW +: LaneW]))
                + (fl_mul($signed(v_reg[l*LaneW +: LaneW]), dt_reg) >>> 12));
        end
        for (int c = 0; c < 4; c++)
        begin
            col_c[c*8 +: 8] = 8'(lerp({8'd0, cs_reg[c*8 +: 8]}, {8'd0, ce_reg[c*8 +: 8]},
                                      age_reg));
        end
        rad_c = 16'(lerp(rs_reg, re_reg, age_reg));
    end

    // slot memories
    always_ff @(posedge clk)
    begin
        if (st_reg == S_IDLE && cmd_valid && cmd.act == ACT_EMIT)
        begin
            pos_mem[wslot_reg] <= cmd.pos;
            vel_mem[wslot_reg] <= cmd.vel;
            acc_mem[wslot_reg] <= cmd.acc;
            bir_mem[wslot_reg] <= now_reg;
            dth_mem[wslot_reg] <= sat_add(now_reg, 32'(cmd.life));
            rs_mem[wslot_reg]  <= cmd.rad_s;
            re_mem[wslot_reg]  <= cmd.rad_e;
            cs_mem[wslot_reg]  <= cmd.col_s;
            ce_mem[wslot_reg]  <= cmd.col_e;
        end
        else if (st_reg == S_LERP)
        begin
            pos_mem[idx_reg] <= p_reg;
            vel_mem[idx_reg] <= v_reg;
        end
        if (st_reg == S_READ)
        begin
            p_reg  <= pos_mem[idx_reg];
            v_reg  <= vel_mem[idx_reg];
            a_reg  <= acc_mem[idx_reg];
            b_reg  <= bir_mem[idx_reg];
            d_reg  <= dth_mem[idx_reg];
            rs_reg <= rs_mem[idx_reg];
            re_reg <= re_mem[idx_reg];
            cs_reg <= cs_mem[idx_reg];
            ce_reg <= ce_mem[idx_reg];
        end
        else if (st_reg == S_VEL) v_reg <= vnew;
        else if (st_reg == S_POS) p_reg <= pnew;
        if (st_reg == S_DIV && div_done) age_reg <= div_q;
        if (st_reg == S_LERP)
        begin
            rad_reg <= rad_c;
            col_reg <= col_c;
        end
    end

    assign out_free = !oval_reg || m_tready;
    assign live_pkt = {3'b0, col_reg, rad_reg, p_reg, 6'(idx_reg)};

    // a held live result goes out when the next live one replaces it; the
    // tick end sends the held one with last, or an empty result
    always_comb
    begin
        load_out = 1'b0;
        out_pkt  = h_reg;
        out_last = 1'b0;
        out_live = 1'b1;
        case (st_reg)
            S_NEXT: load_out = out_free && live_reg && hv_reg;
            S_NONE:
            begin
                load_out = out_free;
                out_last = 1'b1;
                out_live = hv_reg;
                if (!hv_reg) out_pkt = '0;
            end
            default: load_out = 1'b0;
        endcase
    end

    assign m_tvalid = oval_reg;
    assign m_tdata  = o_reg;
    assign m_tlast  = ol_reg;
    assign m_tuser  = ousr_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg    <= S_IDLE;
            wslot_reg <= '0;
            idx_reg   <= '0;
            now_reg   <= '0;
            dt_reg    <= '0;
            live_reg  <= 1'b0;
            vld_reg   <= '0;
            hv_reg    <= 1'b0;
            h_reg     <= '0;
            oval_reg  <= 1'b0;
            ol_reg    <= 1'b0;
            ousr_reg  <= 1'b0;
            o_reg     <= '0;
        end
        else
        begin
            if (load_out)
            begin
                oval_reg <= 1'b1;
                o_reg    <= out_pkt;
                ol_reg   <= out_last;
                ousr_reg <= out_live;
            end
            else if (m_tready)
            begin
                oval_reg <= 1'b0;
            end
            case (st_reg)
                S_IDLE:
                begin
                    if (cmd_valid)
                    begin
                        if (cmd.act == ACT_EMIT)
                        begin
                            vld_reg[wslot_reg] <= 1'b1;
                            wslot_reg <= (wslot_reg == SW'(SLOTS - 1)) ? '0
                                                                       : wslot_reg + 1'b1;
                        end
                        else
                        begin
                            now_reg <= sat_add(now_reg, 32'(cmd.dt));
                            dt_reg  <= cmd.dt;
                            idx_reg <= '0;
                            st_reg  <= S_READ;
                        end
                    end
                end
                S_READ:
                begin
                    live_reg <= vld_reg[idx_reg];
                    st_reg   <= S_CHECK;
                end
                S_CHECK:
                begin
                    if (live_reg && b_reg < now_reg && d_reg > now_reg)
                        st_reg <= S_DIV;
                    else
                    begin
                        live_reg <= 1'b0;
                        st_reg   <= S_NEXT;
                    end
                end
                S_DIV:   if (div_done) st_reg <= S_VEL;
                S_VEL:   st_reg <= S_POS;
                S_POS:   st_reg <= S_LERP;
                S_LERP:  st_reg <= S_NEXT;
                S_NEXT:
                begin
                    // a stalled output register holds the walk here
                    if (out_free)
                    begin
                        if (live_reg)
                        begin
                            h_reg  <= live_pkt;
                            hv_reg <= 1'b1;
                        end
                        if (last_slot) st_reg <= S_NONE;
                        else
                        begin
                            idx_reg <= idx_reg + 1'b1;
                            st_reg  <= S_READ;
                        end
                    end
                end
                S_NONE:
                begin
                    if (out_free)
                    begin
                        hv_reg <= 1'b0;
                        st_reg <= S_IDLE;
                    end
                end
                default: st_reg <= S_IDLE;
            endcase
        end
    end
endmodule

// ===== sv/particle_store_update_core.sv =====
// ----------------------------------------------------------------------------
// particle_store_update_core
// Ring of particle slots with Euler update and age-based interpolation.
// ----------------------------------------------------------------------------
//  channel | dir | tdata                                        | tuser / tlast
//  s_*     | in  | pos, vel, accel, lifetime, dt, rad x2, col x2| action
//  m_*     | out | slot, position, radius, colour               | valid / last
//
//  Emit: written in the back's idle state once queued. Tick: a live slot
//  steps read, check, divide (one age bit per cycle), velocity, position,
//  interpolate, next; a dead slot read, check, next; then the end result.
//  Reset clears time, write slot and per-slot written bits; slot memories
//  are not cleared. A stalled output holds the slot walk in place.
//  The two-deep command queue lets emits be taken while a tick runs.
// ----------------------------------------------------------------------------
module particle_store_update_core
    import psu_pkg::*;
#(
    parameter int SLOTS = SlotsDefault
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                s_tvalid,
    output logic                s_tready,
    // pos[62:0] vel[125:63] accel[188:126] life[212:189] dt[228:213]
    // rad_first[244:229] rad_final[260:245] col_first[292:261] col_final[324:293]
    input  logic [InDataW-1:0]  s_tdata,
    input  logic                s_tuser,      // action
    output logic                m_tvalid,
    input  logic                m_tready,
    // slot[5:0] position[68:6] radius[84:69] colour[116:85]
    output logic [OutDataW-1:0] m_tdata,
    output logic                m_tlast,      // last
    output logic                m_tuser       // particle_valid
);
    logic cmd_valid, cmd_ready;
    cmd_t cmd;

    psu_front u_front (
        .clk(clk), .rst_n(rst_n),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .cmd_valid(cmd_valid), .cmd_ready(cmd_ready), .cmd(cmd)
    );

    psu_back #(.SLOTS(SLOTS)) u_back (
        .clk(clk), .rst_n(rst_n),
        .cmd_valid(cmd_valid), .cmd_ready(cmd_ready), .cmd(cmd),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .m_tlast(m_tlast), .m_tuser(m_tuser)
    );
endmodule

// ===== sv/psu_checker.sv =====
// ----------------------------------------------------------------------------
// psu_checker
// Port-level checks on the particle store update core.
// ----------------------------------------------------------------------------
module psu_checker
    import psu_pkg::*;
(
    input logic                clk,
    input logic                rst_n,
    input logic                m_tvalid,
    input logic                m_tready,
    input logic [OutDataW-1:0] m_tdata,
    input logic                m_tlast,
    input logic                m_tuser
);
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("output changed while stalled");
    a_empty_last: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tuser |-> m_tlast)
        else $error("empty result without last");
    a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tuser |-> m_tdata == '0)
        else $error("empty result carries data");
endmodule

bind particle_store_update_core psu_checker u_psu_checker (
    .clk(clk), .rst_n(rst_n), .m_tvalid(m_tvalid), .m_tready(m_tready),
    .m_tdata(m_tdata), .m_tlast(m_tlast), .m_tuser(m_tuser)
);
